// File: sv/c3x3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// c3x3_pkg: shared types and constants for the 3x3 same-padding convolution.
// No dependencies; every other file refers to it by scoped names.
package c3x3_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_WR_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_WR_BIAS   = 2'd1;
    localparam logic [1:0] CMD_WR_PIXEL  = 2'd2;
    localparam logic [1:0] CMD_COMPUTE   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_IN_CH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;

    localparam logic [2:0] CFG_IN_CH_RST  = 3'd1;
    localparam logic [5:0] CFG_HEIGHT_RST = 6'd32;
    localparam logic [5:0] CFG_WIDTH_RST  = 6'd32;

    localparam int TAPS  = 9;
    localparam int KDIM  = 3;
    localparam int ACC_W = 40;
    localparam int FRAC_SHIFT = 12;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 40'sd2048;
    localparam logic signed [ACC_W-1:0] RES_MAX    = 40'sd32767;
    localparam logic signed [ACC_W-1:0] RES_MIN    = -40'sd32768;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_WR_WEIGHT,
        OP_WR_BIAS,
        OP_WR_PIXEL,
        OP_COMPUTE,
        OP_NULL_RESULT
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         out_chan;
        logic [1:0]         in_chan;
        logic [4:0]         row;
        logic [4:0]         col;
        logic [3:0]         tap;
        logic signed [15:0] value;
    } item_t;

    // clamped configuration as seen by the back end
    typedef struct packed {
        logic [2:0] nch;
        logic [5:0] height;
        logic [5:0] width;
    } cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_RUN,
        BK_DRAIN,
        BK_FINISH
    } bk_state_t;

endpackage
`default_nettype wire

// File: sv/c3x3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// c3x3_front: accepts input transactions, classifies them and drops writes
// that fall outside the stores. Depends on c3x3_pkg.
module c3x3_front #(
    parameter int MAX_IN_CH  = 4,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_H      = 32,
    parameter int MAX_W      = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire [1:0]            cmd,
    input  wire [3:0]            out_chan,
    input  wire [1:0]            in_chan,
    input  wire [4:0]            row,
    input  wire [4:0]            col,
    input  wire [3:0]            tap,
    input  wire signed [15:0]    value,
    output logic                 q_valid,
    input  wire                  q_ready,
    output c3x3_pkg::item_t      q_item
);

    logic            hold_valid_reg, hold_valid_next;
    c3x3_pkg::item_t hold_item_reg, hold_item_next;
    logic            keep;
    logic            accept;

    always_comb
    begin
        hold_item_next.out_chan = out_chan;
        hold_item_next.in_chan  = in_chan;
        hold_item_next.row      = row;
        hold_item_next.col      = col;
        hold_item_next.tap      = tap;
        hold_item_next.value    = value;
        hold_item_next.op       = c3x3_pkg::OP_NULL_RESULT;
        keep                    = 1'b0;
        case (cmd)
            c3x3_pkg::CMD_WR_WEIGHT:
            begin
                hold_item_next.op = c3x3_pkg::OP_WR_WEIGHT;
                keep = (32'(tap) < c3x3_pkg::TAPS) && (32'(in_chan) < MAX_IN_CH)
                       && (32'(out_chan) < MAX_OUT_CH);
            end
            c3x3_pkg::CMD_WR_BIAS:
            begin
                hold_item_next.op = c3x3_pkg::OP_WR_BIAS;
                keep = 32'(out_chan) < MAX_OUT_CH;
            end
            c3x3_pkg::CMD_WR_PIXEL:
            begin
                hold_item_next.op = c3x3_pkg::OP_WR_PIXEL;
                keep = (32'(in_chan) < MAX_IN_CH) && (32'(row) < MAX_H)
                       && (32'(col) < MAX_W);
            end
            c3x3_pkg::CMD_COMPUTE:
            begin
                // a channel beyond the store still owes a zero result
                hold_item_next.op = (32'(out_chan) < MAX_OUT_CH) ?
                                    c3x3_pkg::OP_COMPUTE : c3x3_pkg::OP_NULL_RESULT;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = !hold_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = keep;
        end
        else
        begin
            hold_valid_next = hold_valid_reg && !q_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= hold_item_next;
        end
    end

    assign q_valid = hold_valid_reg;
    assign q_item  = hold_item_reg;

endmodule
`default_nettype wire

// File: sv/c3x3_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// c3x3_queue: short register queue of classified transactions between the
// front and the back end. Depends on c3x3_pkg.
module c3x3_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  c3x3_pkg::item_t  in_item,
    output logic             out_valid,
    input  wire              out_ready,
    output c3x3_pkg::item_t  out_item
);

    localparam int PTR_W = (c3x3_pkg::QUEUE_DEPTH > 1) ? $clog2(c3x3_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(c3x3_pkg::QUEUE_DEPTH + 1);

    c3x3_pkg::item_t   ent_reg [c3x3_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != CNT_W'(c3x3_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == c3x3_pkg::QUEUE_DEPTH - 1) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == c3x3_pkg::QUEUE_DEPTH - 1) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: sv/c3x3_back.sv
`timescale 1ns / 1ps
`default_nettype none
// c3x3_back: weight, bias and pixel memories, the MAC sequencer and the
// output register. Depends on c3x3_pkg.
module c3x3_back #(
    parameter int MAX_IN_CH  = 4,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_H      = 32,
    parameter int MAX_W      = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  c3x3_pkg::cfg_t       cfg,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  c3x3_pkg::item_t      q_item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic signed [15:0]   result,
    output logic                 saturated
);

    localparam int W_DEPTH = MAX_OUT_CH * MAX_IN_CH * c3x3_pkg::TAPS;
    localparam int P_DEPTH = MAX_IN_CH * MAX_H * MAX_W;
    localparam int WAW     = $clog2(W_DEPTH);
    localparam int PAW     = $clog2(P_DEPTH);
    localparam int BAW     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int ACC_W   = c3x3_pkg::ACC_W;

    logic signed [15:0] weight_mem [W_DEPTH];
    logic signed [15:0] bias_mem   [MAX_OUT_CH];
    logic signed [15:0] pixel_mem  [P_DEPTH];

    c3x3_pkg::bk_state_t state_reg, state_next;

    // request being computed
    logic [3:0]  oc_reg;
    logic [4:0]  row_reg, col_reg;
    logic        null_reg, null_next;

    // tap walk: channel, kernel row, kernel column
    logic [2:0]  c_reg, c_next;
    logic [1:0]  kr_reg, kr_next;
    logic [1:0]  kc_reg, kc_next;
    logic        last_step;

    // pipeline
    logic        s1_valid_reg, s1_in_reg, s2_valid_reg;
    logic signed [15:0] pix_rd_reg, wt_rd_reg, bias_rd_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] result_reg;
    logic               sat_reg;

    // control decoded from state
    logic        pop, issue, load_acc, finish_go, start_cmp;
    logic        we_weight, we_bias, we_pixel;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [BAW-1:0] b_addr;
    logic [5:0]  ihp, iwp;
    logic        tap_live;
    logic signed [ACC_W-1:0] rnd_sum, rnd_shift;
    logic signed [15:0]      fin_value;
    logic                    fin_sat;

    assign last_step = (c_reg == cfg.nch - 3'd1) && (kr_reg == 2'(c3x3_pkg::KDIM - 1))
                       && (kc_reg == 2'(c3x3_pkg::KDIM - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            c3x3_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.op == c3x3_pkg::OP_COMPUTE)
                    begin
                        state_next = c3x3_pkg::BK_LOAD;
                    end
                    else if (q_item.op == c3x3_pkg::OP_NULL_RESULT)
                    begin
                        state_next = c3x3_pkg::BK_FINISH;
                    end
                end
            end
            c3x3_pkg::BK_LOAD:
            begin
                state_next = (cfg.nch == 3'd0) ? c3x3_pkg::BK_FINISH : c3x3_pkg::BK_RUN;
            end
            c3x3_pkg::BK_RUN:
            begin
                if (last_step)
                begin
                    state_next = c3x3_pkg::BK_DRAIN;
                end
            end
            c3x3_pkg::BK_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = c3x3_pkg::BK_FINISH;
                end
            end
            c3x3_pkg::BK_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = c3x3_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = c3x3_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        pop       = 1'b0;
        issue     = 1'b0;
        load_acc  = 1'b0;
        finish_go = 1'b0;
        start_cmp = 1'b0;
        we_weight = 1'b0;
        we_bias   = 1'b0;
        we_pixel  = 1'b0;
        case (state_reg)
            c3x3_pkg::BK_IDLE:
            begin
                pop = q_valid;
                if (q_valid)
                begin
                    case (q_item.op)
                        c3x3_pkg::OP_WR_WEIGHT:   we_weight = 1'b1;
                        c3x3_pkg::OP_WR_BIAS:     we_bias   = 1'b1;
                        c3x3_pkg::OP_WR_PIXEL:    we_pixel  = 1'b1;
                        c3x3_pkg::OP_COMPUTE:     start_cmp = 1'b1;
                        c3x3_pkg::OP_NULL_RESULT: start_cmp = 1'b1;
                        default:                  start_cmp = 1'b0;
                    endcase
                end
            end
            c3x3_pkg::BK_LOAD:
            begin
                load_acc = 1'b1;
            end
            c3x3_pkg::BK_RUN:
            begin
                issue = 1'b1;
            end
            c3x3_pkg::BK_DRAIN:
            begin
                issue = 1'b0;
            end
            c3x3_pkg::BK_FINISH:
            begin
                finish_go = !out_valid_reg || out_ready;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign q_ready = pop;

    // tap counters
    always_comb
    begin
        c_next  = c_reg;
        kr_next = kr_reg;
        kc_next = kc_reg;
        if (load_acc)
        begin
            c_next  = 3'd0;
            kr_next = 2'd0;
            kc_next = 2'd0;
        end
        else if (issue)
        begin
            if (kc_reg == 2'(c3x3_pkg::KDIM - 1))
            begin
                kc_next = 2'd0;
                if (kr_reg == 2'(c3x3_pkg::KDIM - 1))
                begin
                    kr_next = 2'd0;
                    c_next  = c_reg + 3'd1;
                end
                else
                begin
                    kr_next = kr_reg + 2'd1;
                end
            end
            else
            begin
                kc_next = kc_reg + 2'd1;
            end
        end
    end

    // addresses; the image position is offset by one so padding tests stay unsigned
    assign ihp      = 6'(row_reg) + 6'(kr_reg);
    assign iwp      = 6'(col_reg) + 6'(kc_reg);
    assign tap_live = (ihp != 6'd0) && (ihp <= cfg.height)
                      && (iwp != 6'd0) && (iwp <= cfg.width);

    assign w_waddr = WAW'((32'(q_item.out_chan) * MAX_IN_CH + 32'(q_item.in_chan))
                          * c3x3_pkg::TAPS + 32'(q_item.tap));
    assign w_raddr = WAW'((32'(oc_reg) * MAX_IN_CH + 32'(c_reg)) * c3x3_pkg::TAPS
                          + 32'(kr_reg) * c3x3_pkg::KDIM + 32'(kc_reg));
    assign p_waddr = PAW'((32'(q_item.in_chan) * MAX_H + 32'(q_item.row)) * MAX_W
                          + 32'(q_item.col));
    assign p_raddr = PAW'((32'(c_reg) * MAX_H + 32'(ihp) - 32'd1) * MAX_W
                          + 32'(iwp) - 32'd1);
    assign b_addr  = BAW'(32'(q_item.out_chan));

    always_ff @(posedge clk)
    begin
        if (we_weight)
        begin
            weight_mem[w_waddr] <= q_item.value;
        end
        wt_rd_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_pixel)
        begin
            pixel_mem[p_waddr] <= q_item.value;
        end
        pix_rd_reg <= pixel_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_bias)
        begin
            bias_mem[b_addr] <= q_item.value;
        end
        bias_rd_reg <= bias_mem[b_addr];
    end

    // accumulate
    always_comb
    begin
        acc_next = acc_reg;
        if (load_acc)
        begin
            acc_next = ACC_W'(bias_rd_reg) <<< c3x3_pkg::FRAC_SHIFT;
        end
        else if (s2_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up to Q8.8, then clip
    always_comb
    begin
        rnd_sum   = acc_reg + c3x3_pkg::ROUND_HALF;
        rnd_shift = rnd_sum >>> c3x3_pkg::FRAC_SHIFT;
        fin_sat   = 1'b0;
        fin_value = rnd_shift[15:0];
        if (rnd_shift > c3x3_pkg::RES_MAX)
        begin
            fin_value = c3x3_pkg::RES_MAX[15:0];
            fin_sat   = 1'b1;
        end
        else if (rnd_shift < c3x3_pkg::RES_MIN)
        begin
            fin_value = c3x3_pkg::RES_MIN[15:0];
            fin_sat   = 1'b1;
        end
        if (null_reg)
        begin
            fin_value = 16'sd0;
            fin_sat   = 1'b0;
        end
    end

    always_comb
    begin
        null_next = null_reg;
        if (start_cmp)
        begin
            null_next = (q_item.op == c3x3_pkg::OP_NULL_RESULT);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= c3x3_pkg::BK_IDLE;
            c_reg         <= 3'd0;
            kr_reg        <= 2'd0;
            kc_reg        <= 2'd0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            null_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            c_reg         <= c_next;
            kr_reg        <= kr_next;
            kc_reg        <= kc_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
            null_reg      <= null_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_cmp)
        begin
            oc_reg  <= q_item.out_chan;
            row_reg <= q_item.row;
            col_reg <= q_item.col;
        end
        s1_in_reg <= tap_live;
        prod_reg  <= s1_in_reg ? (32'(pix_rd_reg) * 32'(wt_rd_reg)) : 32'sd0;
        acc_reg   <= acc_next;
        if (finish_go)
        begin
            result_reg <= fin_value;
            sat_reg    <= fin_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

// File: sv/conv2d_3x3_same_padding.sv
`timescale 1ns / 1ps
`default_nettype none
// conv2d_3x3_same_padding: 3x3 stride-1 zero-padded convolution, one output pixel per request.
// Weight, bias and pixel writes go to the back end's stores; the front takes one a cycle unless
// its hold register is full and the queue is not ready. A compute result comes from the MAC
// sequencer reading one weight and one pixel per cycle, and the back end pops no new item meanwhile.
// Reset (async, active low) clears control state and config to 1 channel, 32x32;
// the stores are not cleared and hold junk until written.
module conv2d_3x3_same_padding #(
    parameter int MAX_IN_CH  = 4,
    parameter int MAX_OUT_CH = 16,
    parameter int MAX_H      = 32,
    parameter int MAX_W      = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    // configuration write port
    input  wire                cfg_we,
    input  wire [1:0]          cfg_index,
    input  wire [5:0]          cfg_data,
    // command transactions
    input  wire                in_valid,
    output logic               in_ready,
    input  wire [1:0]          cmd,
    input  wire [3:0]          out_chan,
    input  wire [1:0]          in_chan,
    input  wire [4:0]          row,
    input  wire [4:0]          col,
    input  wire [3:0]          tap,
    input  wire signed [15:0]  value,
    // result transactions
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [15:0] result,
    output logic               saturated
);

    // configuration registers; the user must write them only while the block is idle (the block does not enforce it)
    logic [2:0] in_ch_reg;
    logic [5:0] height_reg;
    logic [5:0] width_reg;
    c3x3_pkg::cfg_t cfg_clamped;

    // front -> queue -> back
    logic            fq_valid, fq_ready;
    c3x3_pkg::item_t fq_item;
    logic            qb_valid, qb_ready;
    c3x3_pkg::item_t qb_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch_reg  <= c3x3_pkg::CFG_IN_CH_RST;
            height_reg <= c3x3_pkg::CFG_HEIGHT_RST;
            width_reg  <= c3x3_pkg::CFG_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                c3x3_pkg::CFG_IN_CH:  in_ch_reg  <= cfg_data[2:0];
                c3x3_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                c3x3_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                default:              in_ch_reg  <= in_ch_reg;
            endcase
        end
    end

    // limit the settings to what the stores hold
    always_comb
    begin
        cfg_clamped.nch    = (32'(in_ch_reg) > MAX_IN_CH) ? 3'(MAX_IN_CH) : in_ch_reg;
        cfg_clamped.height = (32'(height_reg) > MAX_H) ? 6'(MAX_H) : height_reg;
        cfg_clamped.width  = (32'(width_reg) > MAX_W) ? 6'(MAX_W) : width_reg;
    end

    c3x3_front #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_H      (MAX_H),
        .MAX_W      (MAX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .out_chan (out_chan),
        .in_chan  (in_chan),
        .row      (row),
        .col      (col),
        .tap      (tap),
        .value    (value),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    c3x3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    c3x3_back #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH),
        .MAX_H      (MAX_H),
        .MAX_W      (MAX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_clamped),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .saturated (saturated)
    );

endmodule
`default_nettype wire

// File: tb/conv2d_3x3_same_padding_tb.sv
`timescale 1ns / 1ps
// conv2d_3x3_same_padding_tb: self-checking bench for the 3x3 same-padding convolution.
// Depends on c3x3_pkg (command codes, register indexes) and the conv2d_3x3_same_padding RTL.
// Directed corner tests, then randomised command streams under shifting stall patterns.
module conv2d_3x3_same_padding_tb;

    localparam int IN_CH  = 4;
    localparam int OUT_CH = 16;
    localparam int IMG_H  = 32;
    localparam int IMG_W  = 32;
    localparam int KERN_DEPTH  = OUT_CH * IN_CH * c3x3_pkg::TAPS;
    localparam int PIX_DEPTH   = IN_CH * IMG_H * IMG_W;
    // a compute walks 9 taps per channel plus a short pipeline; allow the queue ahead of it too
    localparam int SETTLE_CYCLES = 100;
    localparam int SECTION_ITEMS = 140;
    localparam longint TIMEOUT_NS = 4_000_000;

    // expected output pixel: value and clip flag
    typedef struct packed {
        logic signed [15:0] pixel;
        logic               clipped;
    } conv_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = c3x3_pkg::CFG_IN_CH;
    logic [5:0]  cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd = c3x3_pkg::CMD_WR_BIAS;
    logic [3:0]         out_chan = '0;
    logic [1:0]         in_chan = '0;
    logic [4:0]         row = '0;
    logic [4:0]         col = '0;
    logic [3:0]         tap = '0;
    logic signed [15:0] value = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] result;
    logic               saturated;

    // shadow copy of the block's stores and registers
    logic signed [15:0] kern_mem [KERN_DEPTH];
    logic signed [15:0] bias_mem [OUT_CH];
    logic signed [15:0] pix_mem  [PIX_DEPTH];
    bit                 kern_set [KERN_DEPTH];
    bit                 bias_set [OUT_CH];
    bit                 pix_set  [PIX_DEPTH];
    logic [2:0]         cfg_nch = c3x3_pkg::CFG_IN_CH_RST;
    logic [5:0]         cfg_h   = c3x3_pkg::CFG_HEIGHT_RST;
    logic [5:0]         cfg_w   = c3x3_pkg::CFG_WIDTH_RST;

    conv_out_t pending_pixels[$];

    int send_idle_pct = 35;
    int recv_idle_pct = 45;
    int n_commands    = 0;
    int n_results     = 0;
    int n_mismatches  = 0;
    int n_configs     = 0;

    conv2d_3x3_same_padding #(
        .MAX_IN_CH  (IN_CH),
        .MAX_OUT_CH (OUT_CH),
        .MAX_H      (IMG_H),
        .MAX_W      (IMG_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_chan  (out_chan),
        .in_chan   (in_chan),
        .row       (row),
        .col       (col),
        .tap       (tap),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .saturated (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // registers above the store sizes behave as the store size
    function automatic int eff_nch();
        return (cfg_nch > IN_CH) ? IN_CH : int'(cfg_nch);
    endfunction

    function automatic int eff_h();
        return (cfg_h > IMG_H) ? IMG_H : int'(cfg_h);
    endfunction

    function automatic int eff_w();
        return (cfg_w > IMG_W) ? IMG_W : int'(cfg_w);
    endfunction

    function automatic int kern_idx(input int oc, input int ic, input int k);
        return (oc * IN_CH + ic) * c3x3_pkg::TAPS + k;
    endfunction

    function automatic int pix_idx(input int ic, input int r, input int c);
        return (ic * IMG_H + r) * IMG_W + c;
    endfunction

    // Bias moves to Q12.20, products are exact Q12.20, then round half up to
    // Q8.8 (floor of sum + 0.5 LSB) and clip to 16 bits.
    function automatic conv_out_t predict_pixel(input int oc, input int r, input int c);
        longint    acc;
        longint    rounded;
        conv_out_t o;
        int        ih;
        int        iw;
        acc = longint'(bias_mem[oc]) * 4096;
        for (int ch = 0; ch < eff_nch(); ch++)
            for (int kr = 0; kr < c3x3_pkg::KDIM; kr++)
                for (int kc = 0; kc < c3x3_pkg::KDIM; kc++)
                begin
                    ih = r + kr - 1;
                    iw = c + kc - 1;
                    if (ih >= 0 && iw >= 0 && ih < eff_h() && iw < eff_w())
                        acc += longint'(pix_mem[pix_idx(ch, ih, iw)])
                             * longint'(kern_mem[kern_idx(oc, ch, kr * c3x3_pkg::KDIM + kc)]);
                end
        rounded   = (acc + 2048) >>> 12;
        o.clipped = 1'b0;
        if (rounded > 32767)
        begin
            rounded   = 32767;
            o.clipped = 1'b1;
        end
        else if (rounded < -32768)
        begin
            rounded   = -32768;
            o.clipped = 1'b1;
        end
        o.pixel = rounded[15:0];
        return o;
    endfunction

    // Update the shadow state for one accepted transaction; a compute
    // queues its expected output pixel.
    function automatic void apply_command(input logic [1:0] c_cmd, input logic [3:0] c_oc,
                                          input logic [1:0] c_ic, input logic [4:0] c_row,
                                          input logic [4:0] c_col, input logic [3:0] c_tap,
                                          input logic signed [15:0] c_val);
        case (c_cmd)
            c3x3_pkg::CMD_WR_WEIGHT:
            begin
                // taps beyond the 3x3 kernel are dropped by the block
                if (c_tap < c3x3_pkg::TAPS)
                begin
                    kern_mem[kern_idx(int'(c_oc), int'(c_ic), int'(c_tap))] = c_val;
                    kern_set[kern_idx(int'(c_oc), int'(c_ic), int'(c_tap))] = 1'b1;
                    n_commands++;
                end
            end
            c3x3_pkg::CMD_WR_BIAS:
            begin
                bias_mem[c_oc] = c_val;
                bias_set[c_oc] = 1'b1;
                n_commands++;
            end
            c3x3_pkg::CMD_WR_PIXEL:
            begin
                pix_mem[pix_idx(int'(c_ic), int'(c_row), int'(c_col))] = c_val;
                pix_set[pix_idx(int'(c_ic), int'(c_row), int'(c_col))] = 1'b1;
                n_commands++;
            end
            default:
            begin
                pending_pixels.push_back(predict_pixel(int'(c_oc), int'(c_row), int'(c_col)));
                n_commands++;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly modest values so sums stay in range, some full-range and some
    // extremes so clipping turns up regularly.
    function automatic logic signed [15:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        if (sel < 30)
            return 16'($urandom);
        return 16'($urandom_range(0, 1023)) - 16'sd512;
    endfunction

    // One command transaction. Entered and left on a falling edge; valid is
    // left high so back-to-back transactions need no second assignment.
    task automatic send_command(input logic [1:0] c_cmd, input logic [3:0] c_oc,
                                input logic [1:0] c_ic, input logic [4:0] c_row,
                                input logic [4:0] c_col, input logic [3:0] c_tap,
                                input logic signed [15:0] c_val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c_cmd;
        out_chan <= c_oc;
        in_chan  <= c_ic;
        row      <= c_row;
        col      <= c_col;
        tap      <= c_tap;
        value    <= c_val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_command(c_cmd, c_oc, c_ic, c_row, c_col, c_tap, c_val);
        @(negedge clk);
    endtask

    // Fields a command does not use carry random junk
    task automatic write_weight(input int oc, input int ic, input int k,
                                input logic signed [15:0] v);
        send_command(c3x3_pkg::CMD_WR_WEIGHT, 4'(oc), 2'(ic), 5'($urandom), 5'($urandom),
                     4'(k), v);
    endtask

    task automatic write_bias(input int oc, input logic signed [15:0] v);
        send_command(c3x3_pkg::CMD_WR_BIAS, 4'(oc), 2'($urandom), 5'($urandom), 5'($urandom),
                     4'($urandom), v);
    endtask

    task automatic write_pixel(input int ic, input int r, input int c,
                               input logic signed [15:0] v);
        send_command(c3x3_pkg::CMD_WR_PIXEL, 4'($urandom), 2'(ic), 5'(r), 5'(c),
                     4'($urandom), v);
    endtask

    // Ask for one output pixel. Any bias, weight or pixel it would read that
    // has never been written is loaded first, so no undefined entry is read.
    task automatic request_pixel(input int oc, input int r, input int c);
        int ih;
        int iw;
        if (!bias_set[oc])
            write_bias(oc, pick_value());
        for (int ch = 0; ch < eff_nch(); ch++)
            for (int kr = 0; kr < c3x3_pkg::KDIM; kr++)
                for (int kc = 0; kc < c3x3_pkg::KDIM; kc++)
                begin
                    ih = r + kr - 1;
                    iw = c + kc - 1;
                    if (ih >= 0 && iw >= 0 && ih < eff_h() && iw < eff_w())
                    begin
                        if (!pix_set[pix_idx(ch, ih, iw)])
                            write_pixel(ch, ih, iw, pick_value());
                        if (!kern_set[kern_idx(oc, ch, kr * c3x3_pkg::KDIM + kc)])
                            write_weight(oc, ch, kr * c3x3_pkg::KDIM + kc, pick_value());
                    end
                end
        send_command(c3x3_pkg::CMD_COMPUTE, 4'(oc), 2'($urandom), 5'(r), 5'(c),
                     4'($urandom), 16'($urandom));
    endtask

    // Drop valid, wait for every expected output pixel, then let any trailing
    // writes drain through the back end.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called with the block idle. Spare upper bits of the channel count
    // write are junk; the register keeps the low three.
    task automatic set_config(input logic [2:0] nch, input logic [5:0] h, input logic [5:0] w);
        logic [2:0] junk;
        junk = 3'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= c3x3_pkg::CFG_IN_CH;
        cfg_data  <= {junk, nch};
        @(negedge clk);
        cfg_index <= c3x3_pkg::CFG_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= c3x3_pkg::CFG_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_we  <= 1'b0;
        cfg_nch  = nch;
        cfg_h    = h;
        cfg_w    = w;
        n_configs++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // 1x1 image, one channel: only the centre tap counts, so the sum is
    // bias + pixel * weight and the corners of the arithmetic are easy to hit.
    task automatic test_rounding_and_saturation();
        wait_quiet();
        set_config(3'd1, 6'd1, 6'd1);
        write_bias(0, 16'sd0);
        write_pixel(0, 0, 0, 16'sd1);
        write_weight(0, 0, 4, 16'sd2048);
        request_pixel(0, 0, 0);              // +0.5 LSB rounds up to 1
        write_pixel(0, 0, 0, 16'shFFFF);
        request_pixel(0, 0, 0);              // -0.5 LSB rounds up to 0
        write_bias(0, 16'sh7FFF);
        write_pixel(0, 0, 0, 16'sh7FFF);
        write_weight(0, 0, 4, 16'sh7FFF);
        request_pixel(0, 0, 0);              // clips high
        write_pixel(0, 0, 0, 16'sh8000);
        request_pixel(0, 0, 0);              // clips low
        write_weight(0, 0, 4, 16'sh8000);
        request_pixel(0, 0, 0);              // most negative squared: clips high
    endtask

    // Taps 9..15 must not land anywhere; the last output pixel is asked again.
    task automatic test_ignored_taps();
        for (int k = c3x3_pkg::TAPS; k < 16; k++)
            write_weight((k % 2 != 0) ? OUT_CH - 1 : 0, (k % 2 != 0) ? IN_CH - 1 : 0,
                         k, pick_value());
        request_pixel(0, 0, 0);
    endtask

    // Edges of the image and of the registers: off-image requests, zero
    // channels, zero height with an oversized width.
    task automatic test_padding_and_clamps();
        wait_quiet();
        set_config(3'd2, 6'd2, 6'd1);
        request_pixel(3, 0, 0);
        request_pixel(3, 31, 31);            // every tap off the image
        wait_quiet();
        set_config(3'd0, 6'd32, 6'd32);
        request_pixel(9, 17, 4);             // no channels: bias only
        wait_quiet();
        set_config(3'd7, 6'd0, 6'd63);
        request_pixel(3, 0, 31);             // no rows: bias only
    endtask

    // Sweep of register settings across three stall patterns. Most traffic is
    // refresh-then-compute around a small window so stores fill and get reused;
    // the rest is stray writes anywhere, dropped taps included, and computes anywhere.
    task automatic test_random_traffic();
        int sw_nch [12];
        int sw_h   [12];
        int sw_w   [12];
        int start;
        int win_r;
        int win_c;
        int oc;
        int r;
        int c;
        sw_nch = '{4, 1, 2, 3, 4, 7, 0, 1, 4, 2, 5, 3};
        sw_h   = '{32, 32, 5, 1, 32, 63, 3, 0, 2, 16, 33, 4};
        sw_w   = '{32, 32, 7, 32, 1, 40, 3, 9, 2, 16, 31, 0};
        for (int s = 0; s < 12; s++)
        begin
            wait_quiet();
            case (s / 4)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 45;
                end
                1:
                begin
                    send_idle_pct = 45;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            set_config(3'(sw_nch[s]), 6'(sw_h[s]), 6'(sw_w[s]));
            win_r = $urandom_range(0, (eff_h() > 6) ? eff_h() - 6 : 0);
            win_c = $urandom_range(0, (eff_w() > 6) ? eff_w() - 6 : 0);
            start = n_commands;
            while (n_commands - start < SECTION_ITEMS)
            begin
                if ($urandom_range(0, 99) < 20)
                begin
                    case ($urandom_range(0, 2))
                        0: write_weight($urandom_range(0, 15), $urandom_range(0, 3),
                                        $urandom_range(0, 15), pick_value());
                        1: write_bias($urandom_range(0, 15), pick_value());
                        default: write_pixel($urandom_range(0, 3), $urandom_range(0, 31),
                                             $urandom_range(0, 31), pick_value());
                    endcase
                end
                else
                begin
                    oc = $urandom_range(0, 15);
                    if ($urandom_range(0, 99) < 80)
                    begin
                        r = win_r + $urandom_range(0, 5);
                        c = win_c + $urandom_range(0, 5);
                    end
                    else
                    begin
                        r = $urandom_range(0, 31);
                        c = $urandom_range(0, 31);
                    end
                    if ($urandom_range(0, 1) != 0)
                        write_pixel($urandom_range(0, 3), r, c, pick_value());
                    if ($urandom_range(0, 1) != 0)
                        write_weight(oc, $urandom_range(0, 3), $urandom_range(0, 8),
                                     pick_value());
                    request_pixel(oc, r, c);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, compare against oldest expectation
    // ------------------------------------------------------------------

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_output
        conv_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t ns: output transaction with none expected: result %0d sat %0b",
                         $time, result, saturated);
                n_mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                n_results++;
                if (result !== want.pixel)
                begin
                    $display("%0t ns: result mismatch: expected %0d actual %0d",
                             $time, want.pixel, result);
                    n_mismatches++;
                end
                if (saturated !== want.clipped)
                begin
                    $display("%0t ns: saturated mismatch: expected %0b actual %0b",
                             $time, want.clipped, saturated);
                    n_mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_rounding_and_saturation();
        test_ignored_taps();
        test_padding_and_clamps();
        test_random_traffic();

        wait_quiet();
        $display("Run covered %0d command transactions and %0d output pixels over %0d settings,",
                 n_commands, n_results, n_configs);
        $display("with sender and receiver stalls in turn and a stall-free stretch.");
        if (n_mismatches == 0)
            $display("** conv2d_3x3_same_padding: PASSED **");
        else
            $display("** conv2d_3x3_same_padding: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d output pixels still expected", pending_pixels.size());
        $display("** conv2d_3x3_same_padding: FAILED **");
        $finish;
    end

endmodule
